### design/kph_pkg.sv
package kph_pkg;

    // Command codes carried in tuser on the input stream.
    localparam logic [2:0] CMD_BASE      = 3'd0;
    localparam logic [2:0] CMD_RD_WORD   = 3'd1;
    localparam logic [2:0] CMD_RD_SAMPLE = 3'd2;
    localparam logic [2:0] CMD_RD_TOTAL  = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_MOTIF_LEN    = 2'd0;
    localparam logic [1:0] REG_DIST_LIMIT   = 2'd1;
    localparam logic [1:0] REG_BOTH_STRANDS = 2'd2;

    localparam logic [2:0] MOTIF_LEN_RST    = 3'd6;
    localparam logic [6:0] DIST_LIMIT_RST   = 7'd64;
    localparam logic       BOTH_STRANDS_RST = 1'b1;

    // Sequence characters and their 2-bit codes.
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [1:0] NUC_A  = 2'd0;
    localparam logic [1:0] NUC_C  = 2'd1;
    localparam logic [1:0] NUC_G  = 2'd2;
    localparam logic [1:0] NUC_T  = 2'd3;
    localparam logic [1:0] COMP_MASK = 2'b11;

    // Result queue.
    localparam int READ_W     = 32;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = 2;
    localparam int OUT_CNT_W  = 3;

    typedef enum logic [2:0] {
        K_NOP,
        K_BASE,
        K_RD_WORD,
        K_RD_SAMPLE,
        K_RD_TOTAL,
        K_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  wr;       // increment word and sample counters
        logic  last;     // last memory operation of the request
        logic  counted;
        logic  zero_rd;  // read address out of range
    } t_op_ctl;

    typedef struct packed {
        logic [READ_W-1:0] value;
        logic              counted;
    } t_result;

endpackage

### design/kph_front.sv
module kph_front #(
    parameter int MAX_WORD_LEN = 6,
    parameter int NUM_DIST     = 64,
    parameter int COUNT_WIDTH  = 32,
    parameter int INDEX_WIDTH  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [6:0]              i_cfg_data,
    input  logic                    i_accept,
    input  logic [2:0]              i_cmd,
    input  logic [7:0]              i_base_char,
    input  logic                    i_seq_end,
    input  logic [15:0]             i_seq_center,
    input  logic [11:0]             i_word_addr,
    input  logic [5:0]              i_dist_addr,
    input  logic [1:0]              i_nuc_addr,
    input  logic                    i_sweep,
    output logic                    o_ready,
    output logic                    o_iss_valid,
    output kph_pkg::t_op_ctl        o_iss_ctl,
    output logic [2*MAX_WORD_LEN-1:0] o_iss_word,
    output logic [((NUM_DIST > 1) ? $clog2(NUM_DIST) : 1)-1:0] o_iss_dist,
    output logic [COUNT_WIDTH-1:0]  o_iss_total
);

    localparam int WORD_BITS = 2 * MAX_WORD_LEN;
    localparam int DIST_BITS = (NUM_DIST > 1) ? $clog2(NUM_DIST) : 1;
    localparam int KW        = $clog2(MAX_WORD_LEN + 1);
    localparam int SW        = ((INDEX_WIDTH > 16) ? INDEX_WIDTH : 16) + 2;

    logic [2:0]             r_motif;
    logic [6:0]             r_limit;
    logic                   r_both;
    logic [WORD_BITS-1:0]   r_roll;
    logic [KW-1:0]          r_run;
    logic [INDEX_WIDTH-1:0] r_idx;
    logic [COUNT_WIDTH-1:0] r_tot [4];

    logic                   r_d_valid;
    logic                   r_d_phase;
    kph_pkg::t_op_ctl       r_d_ctl;
    logic                   r_d_two;
    logic [WORD_BITS-1:0]   r_d_fwd;
    logic [WORD_BITS-1:0]   r_d_rc;
    logic [DIST_BITS-1:0]   r_d_dist;
    logic [COUNT_WIDTH-1:0] r_d_total;

    kph_pkg::t_op_ctl       n_ctl;
    logic                   n_two;
    logic [WORD_BITS-1:0]   n_fwd;
    logic [WORD_BITS-1:0]   n_rc;
    logic [DIST_BITS-1:0]   n_dist;
    logic [COUNT_WIDTH-1:0] n_total;

    logic                   b_valid;
    logic [1:0]             b_code;
    logic [KW-1:0]          k_eff;
    logic [KW-1:0]          run_next;
    logic [WORD_BITS-1:0]   roll_next;
    logic [WORD_BITS-1:0]   mask;
    logic [WORD_BITS-1:0]   fwd;
    logic [WORD_BITS-1:0]   rc;
    logic [SW-1:0]          diff;
    logic [SW-1:0]          abs_d;
    logic                   counted;
    logic                   rd_ok;
    logic [COUNT_WIDTH-1:0] tot_inc;

    always_comb begin
        b_valid = 1'b1;
        b_code  = kph_pkg::NUC_A;
        priority if (i_base_char == kph_pkg::CHAR_A) begin
            b_code = kph_pkg::NUC_A;
        end else if (i_base_char == kph_pkg::CHAR_C) begin
            b_code = kph_pkg::NUC_C;
        end else if (i_base_char == kph_pkg::CHAR_G) begin
            b_code = kph_pkg::NUC_G;
        end else if (i_base_char == kph_pkg::CHAR_T) begin
            b_code = kph_pkg::NUC_T;
        end else begin
            b_valid = 1'b0;
        end

        // Out-of-range word lengths are pulled into 1..MAX_WORD_LEN.
        if (r_motif == 3'd0) begin
            k_eff = KW'(1);
        end else if (4'(r_motif) > 4'(MAX_WORD_LEN)) begin
            k_eff = KW'(MAX_WORD_LEN);
        end else begin
            k_eff = KW'(r_motif);
        end

        run_next  = (r_run < KW'(MAX_WORD_LEN)) ? r_run + 1'b1 : r_run;
        roll_next = WORD_BITS'({r_roll, b_code});

        mask = '0;
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            if (i < int'(k_eff)) begin
                mask[2*i +: 2] = 2'b11;
            end
        end
        fwd = roll_next & mask;

        // Reverse complement: base i of the word lands at place k-1-i.
        rc = '0;
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            for (int j = 0; j < MAX_WORD_LEN; j++) begin
                if (i < int'(k_eff) && j == int'(k_eff) - 1 - i) begin
                    rc[2*j +: 2] = fwd[2*i +: 2] ^ kph_pkg::COMP_MASK;
                end
            end
        end

        // Window middle minus center: index - (k-1) + k/2 - center.
        diff  = SW'(r_idx) - (SW'(k_eff) - SW'(1)) + SW'(k_eff >> 1)
                - SW'(i_seq_center);
        abs_d = diff[SW-1] ? SW'(~diff + SW'(1)) : diff;
        counted = b_valid && (run_next >= k_eff) && (abs_d < SW'(NUM_DIST))
                  && (abs_d < SW'(r_limit));
        rd_ok   = SW'(i_dist_addr) < SW'(NUM_DIST);

        tot_inc = (r_tot[b_code] == '1) ? r_tot[b_code] : r_tot[b_code] + 1'b1;
    end

    always_comb begin
        n_ctl         = '0;
        n_ctl.kind    = kph_pkg::K_NOP;
        n_two         = 1'b0;
        n_fwd         = fwd;
        n_rc          = rc;
        n_dist        = DIST_BITS'(abs_d);
        n_total       = r_tot[i_nuc_addr];
        unique case (i_cmd)
            kph_pkg::CMD_BASE: begin
                n_ctl.kind    = kph_pkg::K_BASE;
                n_ctl.wr      = counted;
                n_ctl.counted = counted;
                n_two         = counted && r_both;
            end
            kph_pkg::CMD_RD_WORD: begin
                n_ctl.kind    = kph_pkg::K_RD_WORD;
                n_ctl.zero_rd = !rd_ok;
                n_fwd         = WORD_BITS'(i_word_addr);
                n_dist        = DIST_BITS'(i_dist_addr);
            end
            kph_pkg::CMD_RD_SAMPLE: begin
                n_ctl.kind    = kph_pkg::K_RD_SAMPLE;
                n_ctl.zero_rd = !rd_ok;
                n_dist        = DIST_BITS'(i_dist_addr);
            end
            kph_pkg::CMD_RD_TOTAL: begin
                n_ctl.kind    = kph_pkg::K_RD_TOTAL;
            end
            kph_pkg::CMD_CLEAR: begin
                n_ctl.kind    = kph_pkg::K_CLEAR;
            end
            default: begin
                n_ctl.kind    = kph_pkg::K_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif <= kph_pkg::MOTIF_LEN_RST;
            r_limit <= kph_pkg::DIST_LIMIT_RST;
            r_both  <= kph_pkg::BOTH_STRANDS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kph_pkg::REG_MOTIF_LEN:    r_motif <= i_cfg_data[2:0];
                kph_pkg::REG_DIST_LIMIT:   r_limit <= i_cfg_data;
                kph_pkg::REG_BOTH_STRANDS: r_both  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll <= '0;
            r_run  <= '0;
            r_idx  <= '0;
            for (int i = 0; i < 4; i++) begin
                r_tot[i] <= '0;
            end
        end else if (i_accept) begin
            if (i_cmd == kph_pkg::CMD_BASE) begin
                if (b_valid) begin
                    r_tot[b_code] <= tot_inc;
                    r_roll        <= roll_next;
                    r_run         <= run_next;
                end else begin
                    r_roll <= '0;
                    r_run  <= '0;
                end
                if (i_seq_end) begin
                    r_idx  <= '0;
                    r_roll <= '0;
                    r_run  <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (i_cmd == kph_pkg::CMD_CLEAR) begin
                for (int i = 0; i < 4; i++) begin
                    r_tot[i] <= '0;
                end
            end
        end
    end

    // A request that counts both strands occupies the issue slot twice.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_d_phase <= 1'b0;
        end else if (i_accept) begin
            r_d_valid <= 1'b1;
            r_d_phase <= 1'b0;
        end else if (r_d_valid && r_d_two && !r_d_phase) begin
            r_d_phase <= 1'b1;
        end else begin
            r_d_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_d_ctl   <= n_ctl;
            r_d_two   <= n_two;
            r_d_fwd   <= n_fwd;
            r_d_rc    <= n_rc;
            r_d_dist  <= n_dist;
            r_d_total <= n_total;
        end
    end

    assign o_ready = !i_sweep && !(r_d_valid && (r_d_ctl.kind == kph_pkg::K_CLEAR
                                   || (r_d_two && !r_d_phase)));

    always_comb begin
        o_iss_valid    = r_d_valid;
        o_iss_ctl      = r_d_ctl;
        o_iss_ctl.last = !r_d_two || r_d_phase;
        o_iss_word     = r_d_phase ? r_d_rc : r_d_fwd;
        o_iss_dist     = r_d_dist;
        o_iss_total    = r_d_total;
    end

endmodule

### design/kph_update.sv
module kph_update #(
    parameter int MAX_WORD_LEN = 6,
    parameter int NUM_DIST     = 64,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_iss_valid,
    input  kph_pkg::t_op_ctl          i_iss_ctl,
    input  logic [2*MAX_WORD_LEN-1:0] i_iss_word,
    input  logic [((NUM_DIST > 1) ? $clog2(NUM_DIST) : 1)-1:0] i_iss_dist,
    input  logic [COUNT_WIDTH-1:0]    i_iss_total,
    output logic                      o_res_valid,
    output kph_pkg::t_result          o_res,
    output logic                      o_sweep
);

    localparam int WORD_BITS = 2 * MAX_WORD_LEN;
    localparam int DIST_BITS = (NUM_DIST > 1) ? $clog2(NUM_DIST) : 1;
    localparam int MA        = WORD_BITS + DIST_BITS;
    localparam int WDEPTH    = 1 << MA;
    localparam int SDEPTH    = 1 << DIST_BITS;

    logic [COUNT_WIDTH-1:0] r_wmem [WDEPTH];
    logic [COUNT_WIDTH-1:0] r_smem [SDEPTH];
    logic [COUNT_WIDTH-1:0] r_wrd;
    logic [COUNT_WIDTH-1:0] r_srd;

    logic                   r_s1_valid;
    kph_pkg::t_op_ctl       r_s1_ctl;
    logic [MA-1:0]          r_s1_waddr;
    logic [DIST_BITS-1:0]   r_s1_saddr;
    logic [COUNT_WIDTH-1:0] r_s1_total;

    logic                   r_fw_valid;
    logic [MA-1:0]          r_fw_waddr;
    logic [DIST_BITS-1:0]   r_fw_saddr;
    logic [COUNT_WIDTH-1:0] r_fw_wdata;
    logic [COUNT_WIDTH-1:0] r_fw_sdata;

    logic                   r_sweep;
    logic [MA-1:0]          r_sw_addr;

    logic [MA-1:0]          iss_waddr;
    logic [COUNT_WIDTH-1:0] wcur;
    logic [COUNT_WIDTH-1:0] scur;
    logic [COUNT_WIDTH-1:0] winc;
    logic [COUNT_WIDTH-1:0] sinc;
    logic                   s1_wr;
    logic [COUNT_WIDTH-1:0] rd_val;

    assign iss_waddr = {i_iss_word, i_iss_dist};
    assign s1_wr     = r_s1_valid && r_s1_ctl.wr;

    // The write of the op one ahead lands in the same cycle as this op's
    // read, so the memory still shows the old value: take it from the bypass.
    always_comb begin
        wcur = (r_fw_valid && r_fw_waddr == r_s1_waddr) ? r_fw_wdata : r_wrd;
        scur = (r_fw_valid && r_fw_saddr == r_s1_saddr) ? r_fw_sdata : r_srd;
        winc = (wcur == '1) ? wcur : wcur + 1'b1;
        sinc = (scur == '1) ? scur : scur + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (r_sweep) begin
            r_wmem[r_sw_addr]                 <= '0;
            r_smem[r_sw_addr[DIST_BITS-1:0]] <= '0;
        end else if (s1_wr) begin
            r_wmem[r_s1_waddr] <= winc;
            r_smem[r_s1_saddr] <= sinc;
        end
        r_wrd <= r_wmem[iss_waddr];
        r_srd <= r_smem[i_iss_dist];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_iss_valid;
            r_fw_valid <= s1_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ctl   <= i_iss_ctl;
        r_s1_waddr <= iss_waddr;
        r_s1_saddr <= i_iss_dist;
        r_s1_total <= i_iss_total;
        r_fw_waddr <= r_s1_waddr;
        r_fw_saddr <= r_s1_saddr;
        r_fw_wdata <= winc;
        r_fw_sdata <= sinc;
    end

    // Zeroing pass over both memories, after reset and on a clear request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep   <= 1'b1;
            r_sw_addr <= '0;
        end else if (r_sweep) begin
            r_sw_addr <= r_sw_addr + 1'b1;
            if (r_sw_addr == '1) begin
                r_sweep <= 1'b0;
            end
        end else if (i_iss_valid && i_iss_ctl.kind == kph_pkg::K_CLEAR) begin
            r_sweep   <= 1'b1;
            r_sw_addr <= '0;
        end
    end

    always_comb begin
        unique case (r_s1_ctl.kind)
            kph_pkg::K_RD_WORD:   rd_val = r_s1_ctl.zero_rd ? '0 : wcur;
            kph_pkg::K_RD_SAMPLE: rd_val = r_s1_ctl.zero_rd ? '0 : scur;
            kph_pkg::K_RD_TOTAL:  rd_val = r_s1_total;
            default:              rd_val = '0;
        endcase
        o_res_valid   = r_s1_valid && r_s1_ctl.last;
        o_res.value   = kph_pkg::READ_W'(rd_val);
        o_res.counted = r_s1_ctl.counted;
    end

    assign o_sweep = r_sweep;

endmodule

### design/kph_out_fifo.sv
module kph_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic                  i_push,
    input  kph_pkg::t_result      i_res,
    output logic                  o_space,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output kph_pkg::t_result      o_res
);

    kph_pkg::t_result               r_q [kph_pkg::OUT_DEPTH];
    logic [kph_pkg::OUT_PTR_W-1:0]  r_wr_ptr;
    logic [kph_pkg::OUT_PTR_W-1:0]  r_rd_ptr;
    logic [kph_pkg::OUT_CNT_W-1:0]  r_fill;
    logic [kph_pkg::OUT_CNT_W-1:0]  r_credit;
    logic                           pop;

    assign pop      = o_tvalid && i_tready;
    assign o_tvalid = r_fill != '0;
    assign o_res    = r_q[r_rd_ptr];
    // Every request in flight owns a slot, so the queue never overflows.
    assign o_space  = r_credit < kph_pkg::OUT_CNT_W'(kph_pkg::OUT_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill   <= r_fill + kph_pkg::OUT_CNT_W'(i_push)
                        - kph_pkg::OUT_CNT_W'(pop);
            r_credit <= r_credit + kph_pkg::OUT_CNT_W'(i_take)
                        - kph_pkg::OUT_CNT_W'(pop);
        end
    end

endmodule

### design/kmer_position_histogram_core.sv
// Results are offered on the master side after the front issue register, the update
// stage register and the output queue; a counted base with both strands also issues
// its reverse-complement word before its result. Throughput: 1 request per cycle
// while the output queue has space and no zeroing pass runs; a counted base with both
// strands occupies the issue slot twice. Reset and clear each start a zeroing pass over
// all 2**(2*MAX_WORD_LEN+log2(NUM_DIST)) word count entries (262144 by default) during which no request is accepted.
module kmer_position_histogram_core #(
    parameter int MAX_WORD_LEN = 6,
    parameter int NUM_DIST     = 64,
    parameter int COUNT_WIDTH  = 32,
    parameter int INDEX_WIDTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // base_char[7:0], seq_center[23:8], word_addr[35:24], dist_addr[41:36],
    // nuc_addr[43:42], zero fill above
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // seq_end
    input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // read_value[31:0]
    output logic [0:0]  m_axis_tuser    // word_counted[0]
);

    localparam int DIST_BITS = (NUM_DIST > 1) ? $clog2(NUM_DIST) : 1;

    logic                      front_ready;
    logic                      space;
    logic                      accept;
    logic                      sweep;
    logic                      iss_valid;
    kph_pkg::t_op_ctl          iss_ctl;
    logic [2*MAX_WORD_LEN-1:0] iss_word;
    logic [DIST_BITS-1:0]      iss_dist;
    logic [COUNT_WIDTH-1:0]    iss_total;
    logic                      res_valid;
    kph_pkg::t_result          res;
    kph_pkg::t_result          out_res;

    assign s_axis_tready = front_ready && space;
    assign accept        = s_axis_tvalid && s_axis_tready;

    kph_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .NUM_DIST     (NUM_DIST),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .INDEX_WIDTH  (INDEX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_cmd        (s_axis_tuser),
        .i_base_char  (s_axis_tdata[7:0]),
        .i_seq_end    (s_axis_tlast),
        .i_seq_center (s_axis_tdata[23:8]),
        .i_word_addr  (s_axis_tdata[35:24]),
        .i_dist_addr  (s_axis_tdata[41:36]),
        .i_nuc_addr   (s_axis_tdata[43:42]),
        .i_sweep      (sweep),
        .o_ready      (front_ready),
        .o_iss_valid  (iss_valid),
        .o_iss_ctl    (iss_ctl),
        .o_iss_word   (iss_word),
        .o_iss_dist   (iss_dist),
        .o_iss_total  (iss_total)
    );

    kph_update #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .NUM_DIST     (NUM_DIST),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_iss_valid  (iss_valid),
        .i_iss_ctl    (iss_ctl),
        .i_iss_word   (iss_word),
        .i_iss_dist   (iss_dist),
        .i_iss_total  (iss_total),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_sweep      (sweep)
    );

    kph_out_fifo u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (accept),
        .i_push   (res_valid),
        .i_res    (res),
        .o_space  (space),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_res    (out_res)
    );

    assign m_axis_tdata    = out_res.value;
    assign m_axis_tuser[0] = out_res.counted;

endmodule

### tb/tb_kmer_position_histogram_core.sv
module tb_kmer_position_histogram_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = 6;
    localparam int DIST_BINS = 64;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 228;
    localparam int LONG_HOLD = 400;
    localparam int SHOWN_ERRORS = 10;
    localparam longint unsigned CYCLE_LIMIT = 64'd2500000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SOURCE,
        IDLE_SINK,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  ch;
        logic        last;
        logic [15:0] center;
        logic [11:0] waddr;
        logic [5:0]  daddr;
        logic [1:0]  naddr;
    } t_request;

    typedef struct packed {
        logic [2:0] k;
        logic [6:0] lim;
        logic       both;
        t_idle_mode mode;
    } t_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [47:0] s_data = '0;
    logic        s_last = 1'b0;
    logic [2:0]  s_user = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic [0:0]  m_user;

    kmer_position_histogram_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predictor state: configuration copy, sequence progress and counter tables.
    logic [2:0]  k_reg = kph_pkg::MOTIF_LEN_RST;
    logic [6:0]  lim_reg = kph_pkg::DIST_LIMIT_RST;
    logic        both_reg = kph_pkg::BOTH_STRANDS_RST;
    logic [11:0] window_code = '0;
    int unsigned valid_bases = 0;
    logic [15:0] seq_pos = '0;
    logic [31:0] word_bins [int];
    logic [31:0] dist_bins [DIST_BINS];
    logic [31:0] nuc_totals [4];
    kph_pkg::t_result pending_results [$];

    t_request    request_queue [$];
    t_request    active_req;
    logic [11:0] recent_words [$];
    int unsigned issued_count = 0;
    int unsigned returned_count = 0;
    int unsigned err_count = 0;
    int unsigned src_pct = 0;
    int unsigned sink_pct = 0;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_cnt = 0;
    longint unsigned cycle_count = 0;

    function automatic logic [31:0] bump(input logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    function automatic bit decode_char(input logic [7:0] ch, output logic [1:0] code);
        code = kph_pkg::NUC_A;
        case (ch)
            kph_pkg::CHAR_A: code = kph_pkg::NUC_A;
            kph_pkg::CHAR_C: code = kph_pkg::NUC_C;
            kph_pkg::CHAR_G: code = kph_pkg::NUC_G;
            kph_pkg::CHAR_T: code = kph_pkg::NUC_T;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [11:0] reverse_word(input int unsigned k, input logic [11:0] w);
        logic [11:0] r;
        r = '0;
        for (int i = 0; i < k; i++) begin
            r = {r[9:0], w[2*i +: 2] ^ kph_pkg::COMP_MASK};
        end
        return r;
    endfunction

    function automatic int unsigned clamp_len(input logic [2:0] k);
        if (k == 3'd0) return 1;
        if (int'(k) > MAX_LEN) return MAX_LEN;
        return int'(k);
    endfunction

    task automatic zero_tables();
        word_bins.delete();
        foreach (dist_bins[i]) dist_bins[i] = '0;
        foreach (nuc_totals[i]) nuc_totals[i] = '0;
    endtask

    // Updates the counter tables for one accepted request and queues its result.
    task automatic count_request(input t_request r);
        kph_pkg::t_result res;
        logic [1:0]  code;
        logic [11:0] w;
        int unsigned k, lim, passes, pos;
        int          key;
        longint      d;
        res = '0;
        case (r.cmd)
            kph_pkg::CMD_BASE: begin
                k = clamp_len(k_reg);
                lim = (int'(lim_reg) > DIST_BINS) ? DIST_BINS : int'(lim_reg);
                if (decode_char(r.ch, code)) begin
                    nuc_totals[code] = bump(nuc_totals[code]);
                    window_code = {window_code[9:0], code};
                    if (valid_bases < MAX_LEN) valid_bases++;
                    if (valid_bases >= k) begin
                        w = window_code & 12'((1 << (2 * k)) - 1);
                        d = longint'(seq_pos) - longint'(k - 1) + longint'(k / 2)
                            - longint'(r.center);
                        if (d < 0) d = -d;
                        if (d < longint'(lim)) begin
                            pos = int'(d);
                            passes = both_reg ? 2 : 1;
                            for (int p = 0; p < passes; p++) begin
                                key = int'(w) * DIST_BINS + int'(pos);
                                dist_bins[pos] = bump(dist_bins[pos]);
                                word_bins[key] = bump(word_bins.exists(key) ? word_bins[key] : '0);
                                w = reverse_word(k, w);
                            end
                            res.counted = 1'b1;
                        end
                    end
                end else begin
                    valid_bases = 0;
                    window_code = '0;
                end
                seq_pos = seq_pos + 16'd1;
                if (r.last) begin
                    seq_pos = '0;
                    valid_bases = 0;
                    window_code = '0;
                end
            end
            kph_pkg::CMD_RD_WORD: begin
                key = int'(r.waddr) * DIST_BINS + int'(r.daddr);
                if (word_bins.exists(key)) res.value = word_bins[key];
            end
            kph_pkg::CMD_RD_SAMPLE: res.value = dist_bins[r.daddr];
            kph_pkg::CMD_RD_TOTAL: res.value = nuc_totals[r.naddr];
            kph_pkg::CMD_CLEAR: zero_tables();
            default: ;
        endcase
        pending_results.insert(pending_results.size(), res);
    endtask

    // Driver: presents queued requests, holding each one until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) count_request(active_req);
            if (!s_valid || s_ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= src_pct) begin
                    active_req = request_queue.pop_front();
                    s_valid <= 1'b1;
                    s_data <= {4'b0, active_req.naddr, active_req.daddr, active_req.waddr,
                               active_req.center, active_req.ch};
                    s_last <= active_req.last;
                    s_user <= active_req.cmd;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure, including a single long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            m_ready <= 1'b0;
            if (hold_cnt == LONG_HOLD - 1) hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_pct);
        end
    end

    always @(posedge i_clk) begin : watch_results
        kph_pkg::t_result want;
        if (i_rst_n && m_valid && m_ready) begin
            returned_count++;
            if (pending_results.size() == 0) begin
                if (err_count < SHOWN_ERRORS) begin
                    $display("unexpected result at %0t: value=%h counted=%b",
                             $time, m_data, m_user[0]);
                end
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data !== want.value || m_user[0] !== want.counted) begin
                    if (err_count < SHOWN_ERRORS) begin
                        $display("mismatch at %0t: expected value=%h counted=%b, got value=%h counted=%b",
                                 $time, want.value, want.counted, m_data, m_user[0]);
                    end
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_request(input t_request r);
        request_queue.insert(request_queue.size(), r);
        issued_count++;
    endtask

    function automatic t_request random_req();
        t_request    r;
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        r = raw[47:0];
        // A clear costs a full zeroing pass, so random traffic never issues one.
        if (r.cmd == kph_pkg::CMD_CLEAR) r.cmd = CMD_SPARE_LO;
        return r;
    endfunction

    task automatic wait_drained(input int unsigned settle);
        while (returned_count < issued_count) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_config(input t_phase p);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= kph_pkg::REG_MOTIF_LEN;
        cfg_data <= {4'b0, p.k};
        @(posedge i_clk);
        cfg_index <= kph_pkg::REG_DIST_LIMIT;
        cfg_data <= p.lim;
        @(posedge i_clk);
        cfg_index <= kph_pkg::REG_BOTH_STRANDS;
        cfg_data <= {6'b0, p.both};
        @(posedge i_clk);
        cfg_we <= 1'b0;
        k_reg = p.k;
        lim_reg = p.lim;
        both_reg = p.both;
        case (p.mode)
            IDLE_NONE: begin
                src_pct <= 0;
                sink_pct <= 0;
            end
            IDLE_SOURCE: begin
                src_pct <= 64;
                sink_pct <= 0;
            end
            IDLE_SINK: begin
                src_pct <= 0;
                sink_pct <= 64;
            end
            default: begin
                src_pct <= 38;
                sink_pct <= 38;
            end
        endcase
    endtask

    task automatic add_bases(input string s, input logic [15:0] ctr);
        t_request r;
        for (int i = 0; i < s.len(); i++) begin
            r = '0;
            r.cmd = kph_pkg::CMD_BASE;
            r.ch = s[i];
            r.center = ctr;
            r.last = (i == s.len() - 1);
            queue_request(r);
        end
    endtask

    // One sequence of mostly valid bases, then a few reads aimed at what it counted.
    task automatic add_sequence(input int unsigned k_eff, output int unsigned n);
        t_request    r;
        logic [15:0] ctr;
        logic [1:0]  code;
        logic [11:0] roll;
        int unsigned len, run;
        roll = '0;
        run = 0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        ctr = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, len));
        for (int i = 0; i < len; i++) begin
            r = random_req();
            r.cmd = kph_pkg::CMD_BASE;
            r.center = ctr;
            r.last = (i == len - 1) && ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 11) != 0) begin
                case (2'($urandom_range(0, 3)))
                    kph_pkg::NUC_A: r.ch = kph_pkg::CHAR_A;
                    kph_pkg::NUC_C: r.ch = kph_pkg::CHAR_C;
                    kph_pkg::NUC_G: r.ch = kph_pkg::CHAR_G;
                    default: r.ch = kph_pkg::CHAR_T;
                endcase
            end
            if (decode_char(r.ch, code)) begin
                roll = {roll[9:0], code};
                if (run < MAX_LEN) run++;
                if (run >= k_eff) begin
                    recent_words.insert(recent_words.size(),
                                        roll & 12'((1 << (2 * k_eff)) - 1));
                end
            end else begin
                roll = '0;
                run = 0;
            end
            queue_request(r);
        end
        n = len;
        repeat ($urandom_range(1, 3)) begin
            r = random_req();
            case ($urandom_range(0, 2))
                0: begin
                    r.cmd = kph_pkg::CMD_RD_WORD;
                    if (recent_words.size() != 0 && $urandom_range(0, 5) != 0) begin
                        r.waddr = recent_words[$urandom_range(0, recent_words.size() - 1)];
                    end
                end
                1: r.cmd = kph_pkg::CMD_RD_SAMPLE;
                default: r.cmd = kph_pkg::CMD_RD_TOTAL;
            endcase
            if ($urandom_range(0, 3) != 0) r.daddr = 6'($urandom_range(0, 7));
            queue_request(r);
            n++;
        end
        while (recent_words.size() > 64) void'(recent_words.pop_front());
    endtask

    initial begin : stimulus
        t_phase      plan [NUM_PHASES];
        t_request    r;
        int unsigned made, n;
        bit          paused;
        plan[0] = '{3'd6, 7'd64, 1'b1, IDLE_NONE};
        plan[1] = '{3'd1, 7'd1, 1'b0, IDLE_SOURCE};
        plan[2] = '{3'd3, 7'd20, 1'b1, IDLE_SINK};
        plan[3] = '{3'd0, 7'd0, 1'b1, IDLE_BOTH};
        plan[4] = '{3'd7, 7'd127, 1'b0, IDLE_NONE};
        plan[5] = '{3'd2, 7'd64, 1'b1, IDLE_SOURCE};
        plan[6] = '{3'd5, 7'd8, 1'b0, IDLE_SINK};
        plan[7] = '{3'd4, 7'd100, 1'b1, IDLE_BOTH};
        paused = 1'b0;
        zero_tables();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_config(plan[0]);

        // Directed: counted windows near the center, a run broken by an invalid
        // base, reads at the address extremes, an unknown command and a clear.
        add_bases("ACGTACG", 16'd4);
        add_bases("CNGTACGT", 16'd5);
        r = '0;
        r.cmd = kph_pkg::CMD_RD_WORD;
        r.waddr = 12'h1B1;
        r.daddr = 6'd1;
        queue_request(r);
        r = '0;
        r.cmd = kph_pkg::CMD_RD_SAMPLE;
        queue_request(r);
        r.daddr = '1;
        queue_request(r);
        r = '0;
        r.cmd = kph_pkg::CMD_RD_TOTAL;
        r.naddr = kph_pkg::NUC_A;
        queue_request(r);
        r.naddr = kph_pkg::NUC_T;
        queue_request(r);
        r = '1;
        r.cmd = kph_pkg::CMD_RD_WORD;
        queue_request(r);
        r = '1;
        r.cmd = CMD_SPARE_HI;
        queue_request(r);
        r = '1;
        r.cmd = kph_pkg::CMD_BASE;
        queue_request(r);
        r = '0;
        r.cmd = kph_pkg::CMD_CLEAR;
        queue_request(r);
        r = '0;
        r.cmd = kph_pkg::CMD_RD_SAMPLE;
        r.daddr = 6'd1;
        queue_request(r);
        r.cmd = kph_pkg::CMD_RD_TOTAL;
        r.naddr = kph_pkg::NUC_C;
        queue_request(r);
        wait_drained(8);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_config(plan[ph]);
            recent_words.delete();
            // The result side stops for a long stretch so the block backs up.
            if (ph == 4) hold_go <= 1'b1;
            made = 0;
            while (made < PHASE_ITEMS) begin
                if (ph == 5 && !paused && made >= PHASE_ITEMS / 2) begin
                    wait_drained(0);
                    paused = 1'b1;
                end
                if ($urandom_range(0, 3) != 0) begin
                    add_sequence(clamp_len(plan[ph].k), n);
                    made += n;
                end else begin
                    queue_request(random_req());
                    made++;
                end
            end
            wait_drained(8);
        end

        wait_drained(10);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
